>>> hdl/dssf_pkg.sv
// Shared types and constants for the discrete state-space filter.
// No dependencies; every other file of the block imports this package.
package dssf_pkg;

    // Filter order and coefficient format.
    localparam int STATE_COUNT    = 8;
    localparam int COEF_FRAC_BITS = 14;

    // Field widths of the request and response transfers.
    localparam int REQ_W        = 2;
    localparam int COEF_IDX_W   = 7;
    localparam int COEF_W       = 18;
    localparam int SAMPLE_W     = 16;
    localparam int STATE_W      = 32;

    // Coefficient table layout: A row-major, then B, then C, then D.
    localparam int SLOT_B     = STATE_COUNT * STATE_COUNT;
    localparam int SLOT_C     = SLOT_B + STATE_COUNT;
    localparam int SLOT_D     = SLOT_C + STATE_COUNT;
    localparam int COEF_COUNT = SLOT_D + 1;

    localparam int COEF_ADDR_W = $clog2(COEF_COUNT);
    localparam int IDX_W       = (STATE_COUNT > 1) ? $clog2(STATE_COUNT) : 1;
    localparam int CNT_W       = $clog2(STATE_COUNT + 1);

    // Datapath widths: one product, then the exact sum of STATE_COUNT+1 products.
    localparam int PROD_W = COEF_W + STATE_W;
    localparam int ACC_W  = PROD_W + $clog2(STATE_COUNT + 1) + 1;
    localparam int RND_W  = ACC_W - COEF_FRAC_BITS;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [STATE_W-1:0]  state_t;
    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // Tag that travels with each product through the MAC pipeline.
    typedef struct packed {
        logic             vld;
        logic             first;
        logic             last;
        logic [CNT_W-1:0] row;
    } tag_t;

    // Finished row from the MAC: row 0 is the output y, row r is state element r-1.
    typedef struct packed {
        logic             vld;
        logic [CNT_W-1:0] row;
        logic [STATE_W-1:0] value;
        logic             sat;
    } mac_out_t;

endpackage

>>> hdl/dssf_if.sv
// Handshake interfaces for the request and response channels of the filter.
// Depends on dssf_pkg for the field widths.
interface dssf_req_if import dssf_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [COEF_IDX_W-1:0]    coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output req_type, output coef_index,
                    output coef_value, output sample_in, input ready);
    modport sink   (input valid, input req_type, input coef_index,
                    input coef_value, input sample_in, output ready);
endinterface

interface dssf_rsp_if import dssf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

>>> hdl/dssf_mac.sv
// Shared multiply-accumulate unit with rounding and saturation stages.
// Depends on dssf_pkg for the tag and result types.
module dssf_mac import dssf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  tag_t     tag_in,
    input  coef_t    coef_op,
    input  state_t   x_op,
    output mac_out_t result
);

    tag_t                     prod_tag_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;

    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic                     done_reg;
    logic [CNT_W-1:0]         done_row_reg;

    logic signed [ACC_W-1:0]  acc_half;
    logic signed [RND_W-1:0]  rnd_reg;
    logic                     rnd_vld_reg;
    logic [CNT_W-1:0]         rnd_row_reg;

    logic [RND_W-SAMPLE_W:0]  hi_y;
    logic [RND_W-STATE_W:0]   hi_x;
    logic                     ovf_y;
    logic                     ovf_x;
    logic                     sgn;
    logic [SAMPLE_W-1:0]      y_val;
    logic [STATE_W-1:0]       x_val;
    mac_out_t                 result_next;
    mac_out_t                 result_reg;

    assign prod_next = PROD_W'(coef_op) * PROD_W'(x_op);

    always_comb
    begin
        acc_next = (prod_tag_reg.first ? '0 : acc_reg) + ACC_W'(prod_reg);
    end

    // Round half up: add half an LSB, then drop the fraction bits.
    assign acc_half = acc_reg + ACC_W'(1 << (COEF_FRAC_BITS - 1));

    // Saturation: the value fits when the target sign bit and all bits above it agree.
    always_comb
    begin
        sgn   = rnd_reg[RND_W-1];
        hi_y  = rnd_reg[RND_W-1:SAMPLE_W-1];
        hi_x  = rnd_reg[RND_W-1:STATE_W-1];
        ovf_y = !(&hi_y) && (|hi_y);
        ovf_x = !(&hi_x) && (|hi_x);
        y_val = ovf_y ? {sgn, {(SAMPLE_W-1){~sgn}}} : rnd_reg[SAMPLE_W-1:0];
        x_val = ovf_x ? {sgn, {(STATE_W-1){~sgn}}} : rnd_reg[STATE_W-1:0];
        result_next.vld = rnd_vld_reg;
        result_next.row = rnd_row_reg;
        if (rnd_row_reg == '0)
        begin
            result_next.value = {{(STATE_W-SAMPLE_W){y_val[SAMPLE_W-1]}}, y_val};
            result_next.sat   = ovf_y;
        end
        else
        begin
            result_next.value = x_val;
            result_next.sat   = ovf_x;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_tag_reg <= '0;
            done_reg     <= 1'b0;
            rnd_vld_reg  <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            prod_tag_reg <= tag_in;
            done_reg     <= prod_tag_reg.vld && prod_tag_reg.last;
            rnd_vld_reg  <= done_reg;
            result_reg   <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        done_row_reg <= prod_tag_reg.row;
        rnd_row_reg  <= done_row_reg;
        if (prod_tag_reg.vld)
        begin
            acc_reg <= acc_next;
        end
        rnd_reg <= acc_half[ACC_W-1:COEF_FRAC_BITS];
    end

    assign result = result_reg;

endmodule

>>> hdl/discrete_state_space_filter.sv
// Discrete state-space filter, single input and single output, fixed point.
// Depends on dssf_pkg, the dssf_req_if and dssf_rsp_if interfaces, and dssf_mac.
//
// Requests arrive on the req channel and are taken one at a time. A write
// request stores one Q3.14 coefficient (A row-major, then B, C and D); a
// slot beyond the table is dropped. A clear request zeroes the state vector.
// A sample request computes y = C*x + D*u and then x = A*x + B*u with the
// old x, and returns one transfer on the rsp channel with y saturated to 16
// bits and a flag that is set if y or any new state element clipped. Write
// and clear requests produce no response.
//
// A sample occupies the block until its response is loaded: the single
// multiplier takes one coefficient per cycle from the coefficient memory,
// and the state memory is read once per product. The response becomes
// valid in the same cycle in which the next request can be taken, and the
// block takes no other request while a sample is in progress.
//
// Reset empties both memories by clearing their valid bits, so every
// coefficient and state element reads as zero. If the receiver stalls, the
// finished response waits in the output register; the next request is still
// taken, and a later sample holds its result until the register is free.
module discrete_state_space_filter import dssf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dssf_req_if.sink   req,
    dssf_rsp_if.source rsp
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } fsm_state_t;

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // Coefficient memory with one valid bit per entry, cleared by reset.
    logic [COEF_W-1:0]      coef_mem [0:COEF_COUNT-1];
    logic [COEF_COUNT-1:0]  coef_vld_reg;

    // State memory in two banks: one is read while the other takes the new x.
    logic [STATE_W-1:0]     st_mem [0:1][0:STATE_COUNT-1];
    logic [1:0][STATE_COUNT-1:0] st_vld_reg;
    logic                   bank_reg;

    logic                   req_xfer;
    logic                   rsp_load;
    logic                   coef_wr;
    logic [COEF_ADDR_W-1:0] coef_wr_addr;

    // Sequencer.
    logic [CNT_W-1:0]       row_reg;
    logic [CNT_W-1:0]       term_reg;
    logic [COEF_ADDR_W-1:0] a_addr_reg;
    logic [COEF_ADDR_W-1:0] coef_rd_addr;
    logic [IDX_W-1:0]       st_rd_idx;
    logic                   term_last;
    logic                   row_last;
    tag_t                   tag_issue;
    tag_t                   tag_rd_reg;

    // Read data and operands.
    logic [COEF_W-1:0]      coef_rd_reg;
    logic                   coef_rd_vld_reg;
    logic [STATE_W-1:0]     st_rd_reg;
    logic                   st_rd_vld_reg;
    sample_t                u_reg;
    coef_t                  coef_op;
    state_t                 x_op;

    // Results.
    mac_out_t               mac_out;
    logic [CNT_W-1:0]       wr_row_m1;
    logic [IDX_W-1:0]       wr_idx;
    logic [SAMPLE_W-1:0]    y_reg;
    logic                   sat_reg;
    logic                   rsp_vld_reg;
    logic [SAMPLE_W-1:0]    out_reg;
    logic                   out_sat_reg;

    assign req.ready = (state_reg == ST_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign coef_wr   = req_xfer && (req.req_type == REQ_WRITE)
                       && ($unsigned(req.coef_index) < COEF_COUNT);
    assign coef_wr_addr = COEF_ADDR_W'(req.coef_index);

    assign term_last = (term_reg == CNT_W'(STATE_COUNT));
    assign row_last  = (row_reg == CNT_W'(STATE_COUNT));
    assign rsp_load  = (state_reg == ST_FINISH) && (!rsp_vld_reg || rsp.ready);

    // Row 0 is the output row (C then D); row r is state row r-1 (A then B).
    always_comb
    begin
        if (term_last)
        begin
            coef_rd_addr = (row_reg == '0) ? COEF_ADDR_W'(SLOT_D)
                         : COEF_ADDR_W'(SLOT_B - 1) + COEF_ADDR_W'(row_reg);
            st_rd_idx    = '0;
        end
        else
        begin
            coef_rd_addr = (row_reg == '0) ? COEF_ADDR_W'(SLOT_C) + COEF_ADDR_W'(term_reg)
                         : a_addr_reg;
            st_rd_idx    = term_reg[IDX_W-1:0];
        end
        tag_issue.vld   = (state_reg == ST_RUN);
        tag_issue.first = (term_reg == '0);
        tag_issue.last  = term_last;
        tag_issue.row   = row_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer && (req.req_type == REQ_SAMPLE))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (row_last && term_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (mac_out.vld && (mac_out.row == CNT_W'(STATE_COUNT)))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (rsp_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            row_reg    <= '0;
            term_reg   <= '0;
            a_addr_reg <= '0;
            tag_rd_reg <= '0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tag_rd_reg <= tag_issue;
            if (state_reg == ST_IDLE)
            begin
                row_reg    <= '0;
                term_reg   <= '0;
                a_addr_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (term_last)
                begin
                    term_reg <= '0;
                    row_reg  <= row_reg + CNT_W'(1);
                end
                else
                begin
                    term_reg <= term_reg + CNT_W'(1);
                    if (row_reg != '0)
                    begin
                        a_addr_reg <= a_addr_reg + COEF_ADDR_W'(1);
                    end
                end
            end
            if (rsp_load)
            begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    // Coefficient memory: written by requests, read by the sequencer.
    always_ff @(posedge clk)
    begin
        if (coef_wr)
        begin
            coef_mem[coef_wr_addr] <= req.coef_value;
        end
        coef_rd_reg <= coef_mem[coef_rd_addr];
    end

    // State memory: the read bank feeds the products, the other bank takes new x.
    assign wr_row_m1 = mac_out.row - CNT_W'(1);
    assign wr_idx    = wr_row_m1[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (mac_out.vld && (mac_out.row != '0))
        begin
            st_mem[~bank_reg][wr_idx] <= mac_out.value;
        end
        st_rd_reg <= st_mem[bank_reg][st_rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_vld_reg    <= '0;
            st_vld_reg      <= '0;
            coef_rd_vld_reg <= 1'b0;
            st_rd_vld_reg   <= 1'b0;
        end
        else
        begin
            coef_rd_vld_reg <= coef_vld_reg[coef_rd_addr];
            st_rd_vld_reg   <= st_vld_reg[bank_reg][st_rd_idx];
            if (coef_wr)
            begin
                coef_vld_reg[coef_wr_addr] <= 1'b1;
            end
            if (req_xfer && (req.req_type == REQ_CLEAR))
            begin
                st_vld_reg <= '0;
            end
            else if (mac_out.vld && (mac_out.row != '0))
            begin
                st_vld_reg[~bank_reg][wr_idx] <= 1'b1;
            end
        end
    end

    // Operand selection: an entry never written reads as zero.
    always_comb
    begin
        coef_op = coef_rd_vld_reg ? coef_t'(coef_rd_reg) : '0;
        if (tag_rd_reg.last)
        begin
            x_op = STATE_W'(u_reg);
        end
        else
        begin
            x_op = st_rd_vld_reg ? state_t'(st_rd_reg) : '0;
        end
    end

    dssf_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .tag_in  (tag_rd_reg),
        .coef_op (coef_op),
        .x_op    (x_op),
        .result  (mac_out)
    );

    // Sample capture, output row and saturation flag.
    always_ff @(posedge clk)
    begin
        if (req_xfer && (req.req_type == REQ_SAMPLE))
        begin
            u_reg <= req.sample_in;
        end
        if (mac_out.vld && (mac_out.row == '0))
        begin
            y_reg <= mac_out.value[SAMPLE_W-1:0];
        end
        if (rsp_load)
        begin
            out_reg     <= y_reg;
            out_sat_reg <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg     <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_IDLE)
            begin
                sat_reg <= 1'b0;
            end
            else if (mac_out.vld && mac_out.sat)
            begin
                sat_reg <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid      = rsp_vld_reg;
    assign rsp.sample_out = out_reg;
    assign rsp.saturated  = out_sat_reg;

    // Finished rows only come out of the MAC while a sample is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        mac_out.vld |-> (state_reg == ST_RUN || state_reg == ST_DRAIN))
        else $error("MAC result outside of a sample computation");

    // A response appears only when a sample computation has completed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_vld_reg) |-> $past(state_reg == ST_FINISH))
        else $error("Response raised without a finished sample");

    // The state banks swap only when a sample's response is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> $past(rsp_load))
        else $error("State bank swapped outside of sample completion");

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the discrete state-space filter.
// Depends on dssf_pkg, the dssf_req_if and dssf_rsp_if interfaces and the
// discrete_state_space_filter top level, which in turn needs dssf_mac.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dssf_pkg::*;

    // The block ignores the fourth request code.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    // The settle time after the last output must cover at least the time that a
    // sample holds the block.
    localparam int SAMPLE_CYCLES = (STATE_COUNT + 1) * (STATE_COUNT + 1) + 6;
    localparam int ITEM_TARGET   = 950;
    localparam int CYCLE_LIMIT   = 1_000_000;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        sample_t y;
        logic    sat;
    } filter_out_t;

    // Bit-accurate shadow of the filter. Accepted writes, clears and samples update
    // the shadow coefficient table and state vector; each sample request also
    // queues the output that the block has to return for it.
    class filter_scoreboard;
        coef_t       coefs[COEF_COUNT];
        state_t      states[STATE_COUNT];
        filter_out_t expected_outputs[$];
        bit          step_clipped;
        int          mismatches;
        int          checked;
        int          clipped;

        function new();
            foreach (coefs[i]) coefs[i] = '0;
            foreach (states[i]) states[i] = '0;
            mismatches = 0;
            checked    = 0;
            clipped    = 0;
        endfunction

        // Round half up: add half an LSB, then an arithmetic shift (a floor).
        function longint round_q(longint acc);
            return (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
        endfunction

        function longint saturate(longint v, longint lo, longint hi);
            if (v > hi)
            begin
                step_clipped = 1'b1;
                return hi;
            end
            if (v < lo)
            begin
                step_clipped = 1'b1;
                return lo;
            end
            return v;
        endfunction

        function int pending();
            return expected_outputs.size();
        endfunction

        function void note_request(logic [REQ_W-1:0] kind, logic [COEF_IDX_W-1:0] idx,
                                   coef_t value, sample_t u);
            filter_out_t res;
            longint      acc;
            state_t      next_x[STATE_COUNT];
            case (kind)
                REQ_WRITE:
                begin
                    if (idx < COEF_COUNT)
                        coefs[idx] = value;
                end
                REQ_CLEAR:
                begin
                    foreach (states[i]) states[i] = '0;
                end
                REQ_SAMPLE:
                begin
                    step_clipped = 1'b0;
                    // The output uses the old state vector.
                    acc = longint'(coefs[SLOT_D]) * longint'(u);
                    for (int c = 0; c < STATE_COUNT; c++)
                        acc += longint'(coefs[SLOT_C + c]) * longint'(states[c]);
                    res.y = sample_t'(saturate(round_q(acc), -32768, 32767));
                    for (int r = 0; r < STATE_COUNT; r++)
                    begin
                        acc = longint'(coefs[SLOT_B + r]) * longint'(u);
                        for (int c = 0; c < STATE_COUNT; c++)
                            acc += longint'(coefs[r * STATE_COUNT + c]) * longint'(states[c]);
                        next_x[r] = state_t'(saturate(round_q(acc), -(longint'(1) <<< 31),
                                                      (longint'(1) <<< 31) - 1));
                    end
                    states  = next_x;
                    res.sat = step_clipped;
                    expected_outputs = {expected_outputs, res};
                end
                default: ;
            endcase
        endfunction

        function void check_output(sample_t y, logic sat);
            filter_out_t want;
            if (expected_outputs.size() == 0)
            begin
                mismatches++;
                $display("%0t: output y=%0d saturated=%0b arrived with no sample outstanding",
                         $time, y, sat);
                return;
            end
            want = expected_outputs.pop_front();
            checked++;
            if (want.sat)
                clipped++;
            if (y !== want.y)
            begin
                mismatches++;
                $display("%0t: sample_out expected %0d, got %0d", $time, want.y, y);
            end
            if (sat !== want.sat)
            begin
                mismatches++;
                $display("%0t: saturated expected %0b, got %0b", $time, want.sat, sat);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    dssf_req_if req();
    dssf_rsp_if rsp();

    discrete_state_space_filter i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    filter_scoreboard board = new();

    // Idling probabilities in percent per cycle, changed between phases.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Request counts for the closing summary.
    int n_samples = 0;
    int n_writes  = 0;
    int n_clears  = 0;
    int n_ignored = 0;
    int n_counted = 0;
    int cycles    = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d outputs outstanding",
                     cycles, board.pending());
            $display("FAIL");
            $finish;
        end
    end

    // Response side. The values seen at the edge are those from before it, so
    // a transfer is detected here and then the ready for the next cycle is
    // chosen. A stall of any length may fall on any cycle of the block's work.
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check_output(rsp.sample_out, rsp.saturated);
        rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic set_idling(idle_mode_t mode);
        case (mode)
            IDLE_NONE:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            IDLE_SENDER:
            begin
                send_idle_pct  = 73;
                recv_stall_pct = 0;
            end
            IDLE_RECEIVER:
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 73;
            end
            default:
            begin
                send_idle_pct  = 26;
                recv_stall_pct = 26;
            end
        endcase
    endtask

    // Drive one request and hold it until the block takes it. Valid stays high
    // into the next request unless an idle gap is drawn, so valid never drops
    // and rises again within one time step.
    task automatic send_request(logic [REQ_W-1:0] kind, logic [COEF_IDX_W-1:0] idx,
                                coef_t value, sample_t u);
        req.valid      <= 1'b1;
        req.req_type   <= kind;
        req.coef_index <= idx;
        req.coef_value <= value;
        req.sample_in  <= u;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        board.note_request(kind, idx, value, u);
        if (kind == REQ_SAMPLE)
            n_samples++;
        else if (kind == REQ_CLEAR)
            n_clears++;
        else if (kind == REQ_WRITE && idx < COEF_COUNT)
            n_writes++;
        if (kind == REQ_UNUSED || (kind == REQ_WRITE && idx >= COEF_COUNT))
            n_ignored++;
        else
            n_counted++;
        if ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // Fields that a request does not use carry random values; the block has
    // to ignore them.
    task automatic write_coef(int idx, coef_t value);
        send_request(REQ_WRITE, idx[COEF_IDX_W-1:0], value, sample_t'($urandom));
    endtask

    task automatic push_sample(sample_t u);
        send_request(REQ_SAMPLE, COEF_IDX_W'($urandom), coef_t'($urandom), u);
    endtask

    task automatic clear_state();
        send_request(REQ_CLEAR, COEF_IDX_W'($urandom), coef_t'($urandom),
                     sample_t'($urandom));
    endtask

    // Something the block must drop: the spare request code, or a write to a
    // slot past the end of the table.
    task automatic send_noise();
        if ($urandom_range(1))
            send_request(REQ_UNUSED, COEF_IDX_W'($urandom), coef_t'($urandom),
                         sample_t'($urandom));
        else
            send_request(REQ_WRITE, COEF_IDX_W'($urandom_range(127, COEF_COUNT)),
                         coef_t'($urandom), sample_t'($urandom));
    endtask

    // Stop sending until every queued output has come back, then give the
    // block time to finish whatever it still holds.
    task automatic drain(int extra);
        req.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    // Coefficients are mostly small, so that state stays in range for a
    // while; full-range and extreme values drive the saturation path.
    function automatic coef_t pick_coef();
        int roll;
        int v;
        roll = $urandom_range(99);
        v    = $urandom_range(6000);
        if (roll < 70)
            return coef_t'(v - 3000);
        if (roll < 90)
            return coef_t'($urandom);
        case ($urandom_range(3))
            0: return coef_t'(-131072);
            1: return coef_t'(131071);
            2: return coef_t'(-1);
            default: return coef_t'(16384);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        int roll;
        int v;
        roll = $urandom_range(99);
        v    = $urandom_range(4000);
        if (roll < 45)
            return sample_t'(v - 2000);
        if (roll < 90)
            return sample_t'($urandom);
        return $urandom_range(1) ? sample_t'(32767) : sample_t'(-32768);
    endfunction

    initial
    begin
        int         block;
        int         n;
        int         pattern;
        sample_t    level;
        idle_mode_t mode;

        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.req_type   <= REQ_WRITE;
        req.coef_index <= '0;
        req.coef_value <= '0;
        req.sample_in  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. With the table still empty after reset the
        // output must be zero even for a full-scale input.
        set_idling(IDLE_NONE);
        push_sample(sample_t'(32767));

        // Requests the block has to drop: the spare code with every bit set,
        // and writes just past and far past the end of the table.
        send_request(REQ_UNUSED, '1, '1, '1);
        send_request(REQ_WRITE, '1, coef_t'(-1), '1);
        send_request(REQ_WRITE, COEF_IDX_W'(COEF_COUNT), coef_t'(131071), '0);

        // First-order low pass: x' = 0.5x + u, y = x + 0.25u.
        write_coef(0, coef_t'(8192));
        write_coef(SLOT_B, coef_t'(16384));
        write_coef(SLOT_C, coef_t'(16384));
        write_coef(SLOT_D, coef_t'(4096));

        // Impulse response from zero initial conditions.
        clear_state();
        push_sample(sample_t'(16384));
        repeat (3) push_sample('0);

        // Step response from zero initial conditions.
        clear_state();
        repeat (4) push_sample(sample_t'(1000));

        // Feedthrough at its extremes clips the output at both rails.
        write_coef(SLOT_D, coef_t'(131071));
        push_sample(sample_t'(32767));
        write_coef(SLOT_D, coef_t'(-131072));
        push_sample(sample_t'(-32768));
        push_sample(sample_t'(32767));

        // Last slot of A and last slots of B and C.
        write_coef(SLOT_B - 1, coef_t'(-131072));
        write_coef(SLOT_C - 1, coef_t'(131071));
        write_coef(SLOT_D - 1, coef_t'(-1));
        drain(SAMPLE_CYCLES);

        // Random part. Each block loads a few coefficients, may clear the state
        // and then runs a sample stream (random, a step, an impulse or low-level
        // noise) with stray dropped requests and clears. The idling mode changes
        // every four blocks, and the sender waits for every output at each change.
        block = 0;
        while (n_counted < ITEM_TARGET)
        begin
            if (block % 4 == 0)
            begin
                drain(SAMPLE_CYCLES);
                mode = idle_mode_t'((block / 4) % 4);
                set_idling(mode);
            end
            n = $urandom_range(10, 1);
            repeat (n) write_coef($urandom_range(COEF_COUNT - 1), pick_coef());
            if ($urandom_range(1))
                clear_state();
            pattern = $urandom_range(3);
            level   = pick_sample();
            n       = $urandom_range(20, 6);
            for (int k = 0; k < n; k++)
            begin
                if ($urandom_range(29) == 0)
                    send_noise();
                if ($urandom_range(24) == 0)
                    clear_state();
                case (pattern)
                    0: push_sample(pick_sample());
                    1: push_sample(level);
                    2: push_sample(k == 0 ? level : sample_t'(0));
                    default: push_sample(sample_t'($urandom_range(64)) - sample_t'(32));
                endcase
            end
            block++;
        end

        drain(2 * SAMPLE_CYCLES);

        $display("Ran %0d samples, %0d coefficient writes, %0d clears and %0d dropped requests",
                 n_samples, n_writes, n_clears, n_ignored);
        $display("over %0d blocks in four idling modes; %0d outputs checked, %0d of them clipped",
                 block, board.checked, board.clipped);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
